// File: design/kdeq_pkg.sv
// ----------------------------------------------------------------------------
// kdeq_pkg
// shared types and codes of the key debounce event queue
// ----------------------------------------------------------------------------
package kdeq_pkg;

   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_CLICKED = 2'd1,
      EV_RELEASE = 2'd2,
      EV_LONG    = 2'd3
   } ev_kind_type;

   typedef struct packed {
      logic        fire;
      ev_kind_type kind;
   } key_event_type;

   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_GET      = 2'd1;
   localparam logic [1:0] CMD_SUPPRESS = 2'd2;

   localparam logic [1:0] REG_KEYS_IN_USE  = 2'd0;
   localparam logic [1:0] REG_ACTIVE_LOW   = 2'd1;
   localparam logic [1:0] REG_PRESS_FILTER = 2'd2;
   localparam logic [1:0] REG_REPEAT       = 2'd3;

   localparam logic [1:0]  LEVEL_UNKNOWN      = 2'd2;
   localparam logic [15:0] PRESS_FILTER_RESET = 16'd20;
   localparam logic [15:0] REPEAT_RESET       = 16'd500;

endpackage

// File: design/kdeq_key_unit.sv
// ----------------------------------------------------------------------------
// kdeq_key_unit
// next-state and event logic of one key, shared by all keys in turn
// ----------------------------------------------------------------------------
module kdeq_key_unit #(
   parameter int COUNT_BITS = 16
) (
   input  logic [1:0]            level_cur,
   input  logic [COUNT_BITS-1:0] count_cur,
   input  logic                  idle_cur,
   input  logic                  lv,
   input  logic                  pressed,
   input  logic [15:0]           press_ticks,
   input  logic [15:0]           repeat_ticks,
   output logic [1:0]            level_nxt,
   output logic [COUNT_BITS-1:0] count_nxt,
   output logic                  idle_nxt,
   output kdeq_pkg::key_event_type key_event
);

   localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] TWO = COUNT_BITS'(2);

   logic [COUNT_BITS-1:0] count_dec;
   logic [COUNT_BITS-1:0] repeat_load;
   logic [COUNT_BITS-1:0] filter_load;
   logic [COUNT_BITS-1:0] filter_load_m1;
   logic [31:0]           filter_m1_wide;

   assign count_dec      = count_cur - ONE;
   assign repeat_load    = COUNT_BITS'(32'(repeat_ticks));
   assign filter_load    = COUNT_BITS'(32'(press_ticks));
   assign filter_m1_wide = 32'(press_ticks) - 32'd1;
   assign filter_load_m1 = filter_m1_wide[COUNT_BITS-1:0];

   always_comb begin
      level_nxt      = level_cur;
      count_nxt      = count_cur;
      idle_nxt       = idle_cur;
      key_event.fire = 1'b0;
      key_event.kind = kdeq_pkg::EV_PRESS;
      if (level_cur != {1'b0, lv}) begin
         if (pressed) begin
            if (count_cur > ONE) begin
               count_nxt = count_dec;
            end else if (count_cur == ONE) begin
               level_nxt      = {1'b0, lv};
               idle_nxt       = 1'b0;
               count_nxt      = repeat_load;
               key_event.fire = 1'b1;
               key_event.kind = kdeq_pkg::EV_PRESS;
            end else begin
               count_nxt = filter_load_m1;
            end
         end else begin
            if (count_cur > TWO) begin
               count_nxt = count_dec;
            end else if (count_cur == TWO) begin
               count_nxt      = ONE;
               key_event.fire = !idle_cur;
               key_event.kind = kdeq_pkg::EV_CLICKED;
            end else if (count_cur == ONE) begin
               count_nxt      = '0;
               level_nxt      = {1'b0, lv};
               idle_nxt       = 1'b1;
               key_event.fire = !idle_cur;
               key_event.kind = kdeq_pkg::EV_RELEASE;
            end else begin
               count_nxt = filter_load;
            end
         end
      end else if (!idle_cur && pressed) begin
         if (count_cur == ONE) begin
            count_nxt      = repeat_load;
            key_event.fire = 1'b1;
            key_event.kind = kdeq_pkg::EV_LONG;
         end else if (count_cur > ONE) begin
            count_nxt = count_dec;
         end
      end
   end

endmodule

// File: design/key_debounce_event_queue.sv
// ----------------------------------------------------------------------------
// key_debounce_event_queue
// debounces keys one tick at a time and queues press, click, release and
// long-press events for later reads
// ----------------------------------------------------------------------------
//   channel  direction  tdata (low bit up)              tuser
//   req      in         key_levels[7:0], key_index[10:8] command[1:0]
//   rsp      out        event_kind[1:0], event_key[4:2]  event_valid[0]
//   csr      in         csr_index, csr_wdata             -
//
// a tick walks one key per cycle through the shared key unit, then passes
// the push state; a get passes the read state, through the registered queue
// read port, and then the deliver state; suppress and unknown commands are
// handled on acceptance and leave the sequencer idle.
// reset returns every key to unknown level and idle and empties the queue.
// a get answer waits in the response register while rsp_tready is low; ticks
// go on meanwhile, only the next get holds until the register is free.
// ----------------------------------------------------------------------------
module key_debounce_event_queue #(
   parameter int NUM_KEYS    = 8,
   parameter int QUEUE_DEPTH = 8,
   parameter int COUNT_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // key_levels[7:0], key_index[10:8]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // event_kind[1:0], event_key[4:2]
   output logic [0:0]  rsp_tuser,   // event_valid[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int KW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int WCW = $clog2(NUM_KEYS + 1);
   localparam int QW  = $clog2(QUEUE_DEPTH);
   localparam int FW  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_PUSH,
      ST_READ,
      ST_DELIVER
   } state_type;

   // configuration
   logic [3:0]  keys_in_use_ff;
   logic [7:0]  active_low_ff;
   logic [15:0] press_filter_ff;
   logic [15:0] repeat_ff;

   // per-key state
   logic [1:0]            level_ff [NUM_KEYS];
   logic [COUNT_BITS-1:0] count_ff [NUM_KEYS];
   logic                  idle_ff  [NUM_KEYS];

   // queue
   logic [4:0]    queue_mem [QUEUE_DEPTH];
   logic [4:0]    rd_data_ff;
   logic [QW-1:0] rptr_ff, rptr_in;
   logic [QW-1:0] wptr_ff, wptr_in;
   logic [FW-1:0] fill_ff, fill_in;

   // sequencer
   state_type                state_ff, state_in;
   logic [WCW-1:0]           walk_ff, walk_in;
   logic [7:0]               levels_ff, levels_in;
   kdeq_pkg::key_event_type  ev_ff, ev_in;
   logic [2:0]               ev_key_ff, ev_key_in;
   logic                     hit_ff, hit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_flag_ff, rsp_flag_in;
   logic [1:0]               rsp_kind_ff, rsp_kind_in;
   logic [2:0]               rsp_key_ff, rsp_key_in;

   logic [1:0]  req_command;
   logic [7:0]  req_levels;
   logic [2:0]  req_key;
   logic        req_accept;
   logic        queue_push;
   logic        key_write;
   logic        suppress_hit;
   logic [KW-1:0] sup_idx;

   logic [5:0]    keys_n;
   logic [KW-1:0] widx;
   logic [31:0]   widx_wide;
   logic          walk_lv;
   logic          walk_pressed;
   logic          walk_more;

   logic [1:0]              unit_level;
   logic [COUNT_BITS-1:0]   unit_count;
   logic                    unit_idle;
   kdeq_pkg::key_event_type unit_event;

   assign req_command = req_tuser;
   assign req_levels  = req_tdata[7:0];
   assign req_key     = req_tdata[10:8];
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_key_ff, rsp_kind_ff};
   assign rsp_tuser  = rsp_flag_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         keys_in_use_ff  <= '0;
         active_low_ff   <= '0;
         press_filter_ff <= kdeq_pkg::PRESS_FILTER_RESET;
         repeat_ff       <= kdeq_pkg::REPEAT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            kdeq_pkg::REG_KEYS_IN_USE:  keys_in_use_ff  <= csr_wdata[3:0];
            kdeq_pkg::REG_ACTIVE_LOW:   active_low_ff   <= csr_wdata[7:0];
            kdeq_pkg::REG_PRESS_FILTER: press_filter_ff <= csr_wdata;
            kdeq_pkg::REG_REPEAT:       repeat_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // walk over keys through the shared unit
   assign keys_n = (6'(keys_in_use_ff) > 6'(NUM_KEYS)) ? 6'(NUM_KEYS)
                                                        : 6'(keys_in_use_ff);
   assign widx         = walk_ff[KW-1:0];
   assign widx_wide    = 32'(widx);
   assign walk_more    = 6'(walk_ff) < keys_n;
   assign walk_lv      = (widx_wide < 32'd8) ? levels_ff[widx_wide[2:0]] : 1'b0;
   assign walk_pressed = walk_lv ^ ((widx_wide < 32'd8) ?
                                    active_low_ff[widx_wide[2:0]] : 1'b0);

   kdeq_key_unit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_key_unit (
      .level_cur    (level_ff[widx]),
      .count_cur    (count_ff[widx]),
      .idle_cur     (idle_ff[widx]),
      .lv           (walk_lv),
      .pressed      (walk_pressed),
      .press_ticks  (press_filter_ff),
      .repeat_ticks (repeat_ff),
      .level_nxt    (unit_level),
      .count_nxt    (unit_count),
      .idle_nxt     (unit_idle),
      .key_event    (unit_event)
   );

   assign key_write    = (state_ff == ST_WALK) && walk_more;
   assign suppress_hit = req_accept && (req_command == kdeq_pkg::CMD_SUPPRESS)
                         && (32'(req_key) < NUM_KEYS);
   assign sup_idx      = KW'(req_key);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            level_ff[k] <= kdeq_pkg::LEVEL_UNKNOWN;
            count_ff[k] <= '0;
            idle_ff[k]  <= 1'b1;
         end
      end else if (key_write) begin
         level_ff[widx] <= unit_level;
         count_ff[widx] <= unit_count;
         idle_ff[widx]  <= unit_idle;
      end else if (suppress_hit) begin
         level_ff[sup_idx] <= {1'b0, req_levels[req_key]};
         count_ff[sup_idx] <= '0;
         idle_ff[sup_idx]  <= 1'b1;
      end
   end

   // event queue storage
   assign queue_push = (state_ff == ST_PUSH) && (keys_in_use_ff != 4'd0) && ev_ff.fire
                       && (fill_ff < FW'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (queue_push) begin
         queue_mem[wptr_ff] <= {ev_key_ff, ev_ff.kind};
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= queue_mem[rptr_ff];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      levels_in    = levels_ff;
      ev_in        = ev_ff;
      ev_key_in    = ev_key_ff;
      hit_in       = hit_ff;
      rptr_in      = rptr_ff;
      wptr_in      = wptr_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_flag_in  = rsp_flag_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_key_in   = rsp_key_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_command)
                  kdeq_pkg::CMD_TICK: begin
                     levels_in = req_levels;
                     walk_in   = '0;
                     ev_in     = '0;
                     ev_key_in = '0;
                     state_in  = ST_WALK;
                  end
                  kdeq_pkg::CMD_GET: begin
                     hit_in   = (keys_in_use_ff != 4'd0) && (fill_ff != '0);
                     state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (walk_more) begin
               if (unit_event.fire) begin
                  ev_in     = unit_event;
                  ev_key_in = 3'(widx_wide);
               end
               walk_in = walk_ff + WCW'(1);
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (queue_push) begin
               wptr_in = (32'(wptr_ff) == QUEUE_DEPTH - 1) ? '0 : wptr_ff + QW'(1);
               fill_in = fill_ff + FW'(1);
            end
            state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = hit_ff;
               rsp_kind_in  = hit_ff ? rd_data_ff[1:0] : 2'b00;
               rsp_key_in   = hit_ff ? rd_data_ff[4:2] : 3'b000;
               if (hit_ff) begin
                  rptr_in = (32'(rptr_ff) == QUEUE_DEPTH - 1) ? '0 : rptr_ff + QW'(1);
                  fill_in = fill_ff - FW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rptr_ff      <= '0;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         walk_ff      <= '0;
         ev_ff        <= '0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rptr_ff      <= rptr_in;
         wptr_ff      <= wptr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_ff      <= walk_in;
         ev_ff        <= ev_in;
         hit_ff       <= hit_in;
      end
      levels_ff   <= levels_in;
      ev_key_ff   <= ev_key_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_key_ff  <= rsp_key_in;
   end

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(QUEUE_DEPTH))
      else $error("queue fill above depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == FW'(QUEUE_DEPTH)) |-> (rptr_ff == wptr_ff))
      else $error("queue pointers disagree with fill");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_flag_ff) |-> (rsp_kind_ff == 2'b00 && rsp_key_ff == 3'b000))
      else $error("empty answer carries a payload");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DELIVER))
      else $error("response raised outside delivery");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the key debounce event queue: a shadow debouncer
// tracks every key and the event queue, each get answer is checked against
// the oldest predicted word, first with hand-built key sequences and then
// with random key activity, gets and suppresses under random stalls
// ----------------------------------------------------------------------------
module tb_top;

   localparam int         KEY_COUNT     = 8;
   localparam int         EVENT_DEPTH   = 8;
   localparam logic [1:0] CMD_UNKNOWN   = 2'd3;
   localparam int         SETTLE_CYCLES = 32;
   localparam int         CYCLE_LIMIT   = 400000;
   localparam int         RANDOM_PHASES = 14;
   localparam int         PHASE_ITEMS   = 92;

   typedef struct packed {
      logic                  valid;
      kdeq_pkg::ev_kind_type kind;
      logic [2:0]            key;
   } event_word_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;    // key_levels[7:0], key_index[10:8]
   logic [1:0]  req_tuser  = kdeq_pkg::CMD_TICK; // command[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // event_kind[1:0], event_key[4:2]
   logic [0:0]  rsp_tuser;          // event_valid[0]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = kdeq_pkg::REG_KEYS_IN_USE;
   logic [15:0] csr_wdata  = '0;

   // shadow configuration
   logic [3:0]  cfg_keys   = 4'd0;
   logic [7:0]  cfg_low    = 8'd0;
   logic [15:0] cfg_filter = kdeq_pkg::PRESS_FILTER_RESET;
   logic [15:0] cfg_repeat = kdeq_pkg::REPEAT_RESET;

   // shadow key state
   logic [1:0]  key_level [KEY_COUNT];
   logic [15:0] key_count [KEY_COUNT];
   logic        key_idle  [KEY_COUNT];

   event_word_type queued_events[$];
   event_word_type expected_words[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   bit calm_sender    = 1'b0;
   bit calm_receiver  = 1'b0;

   key_debounce_event_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      for (int k = 0; k < KEY_COUNT; k++) begin
         key_level[k] = kdeq_pkg::LEVEL_UNKNOWN;
         key_count[k] = '0;
         key_idle[k]  = 1'b1;
      end
   end

   function automatic void debounce_tick(input logic [7:0] levels);
      int                    n;
      bit                    fired;
      kdeq_pkg::ev_kind_type kind;
      logic [2:0]            who;
      logic                  lv;
      logic                  pressed;
      logic                  was_idle;
      logic [15:0]           c;
      n     = (cfg_keys > KEY_COUNT) ? KEY_COUNT : int'(cfg_keys);
      fired = 1'b0;
      kind  = kdeq_pkg::EV_PRESS;
      who   = 3'd0;
      for (int k = 0; k < n; k++) begin
         lv      = levels[k];
         pressed = lv ^ cfg_low[k];
         c       = key_count[k];
         if (key_level[k] != {1'b0, lv}) begin
            if (pressed) begin
               if (c > 16'd1) begin
                  key_count[k] = c - 16'd1;
               end else if (c == 16'd1) begin
                  key_level[k] = {1'b0, lv};
                  key_idle[k]  = 1'b0;
                  key_count[k] = cfg_repeat;
                  fired = 1'b1; kind = kdeq_pkg::EV_PRESS; who = k[2:0];
               end else begin
                  key_count[k] = cfg_filter - 16'd1;
               end
            end else begin
               if (c > 16'd2) begin
                  key_count[k] = c - 16'd1;
               end else if (c == 16'd2) begin
                  key_count[k] = 16'd1;
                  if (!key_idle[k]) begin
                     fired = 1'b1; kind = kdeq_pkg::EV_CLICKED; who = k[2:0];
                  end
               end else if (c == 16'd1) begin
                  was_idle     = key_idle[k];
                  key_count[k] = 16'd0;
                  key_level[k] = {1'b0, lv};
                  key_idle[k]  = 1'b1;
                  if (!was_idle) begin
                     fired = 1'b1; kind = kdeq_pkg::EV_RELEASE; who = k[2:0];
                  end
               end else begin
                  key_count[k] = cfg_filter;
               end
            end
         end else if (!key_idle[k] && pressed) begin
            if (c == 16'd1) begin
               key_count[k] = cfg_repeat;
               fired = 1'b1; kind = kdeq_pkg::EV_LONG; who = k[2:0];
            end else if (c > 16'd1) begin
               key_count[k] = c - 16'd1;
            end
         end
      end
      // full queue drops the new event
      if (cfg_keys != 4'd0 && fired && queued_events.size() < EVENT_DEPTH) begin
         queued_events.push_back('{valid: 1'b1, kind: kind, key: who});
      end
   endfunction

   function automatic void predict_word(input logic [1:0] cmd, input logic [7:0] levels,
                                        input logic [2:0] idx);
      event_word_type w;
      case (cmd)
         kdeq_pkg::CMD_TICK: begin
            debounce_tick(levels);
         end
         kdeq_pkg::CMD_GET: begin
            if (cfg_keys != 4'd0 && queued_events.size() != 0) begin
               w = queued_events.pop_front();
            end else begin
               w = '{valid: 1'b0, kind: kdeq_pkg::EV_PRESS, key: 3'd0};
            end
            expected_words.push_back(w);
         end
         kdeq_pkg::CMD_SUPPRESS: begin
            key_count[idx] = '0;
            key_level[idx] = {1'b0, levels[idx]};
            key_idle[idx]  = 1'b1;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_word(input logic [1:0] cmd, input logic [7:0] levels,
                            input logic [2:0] idx);
      int gap;
      gap = calm_sender ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, idx, levels};
      req_tuser  <= cmd;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      predict_word(cmd, levels, idx);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         kdeq_pkg::REG_KEYS_IN_USE:  cfg_keys   = value[3:0];
         kdeq_pkg::REG_ACTIVE_LOW:   cfg_low    = value[7:0];
         kdeq_pkg::REG_PRESS_FILTER: cfg_filter = value;
         kdeq_pkg::REG_REPEAT:       cfg_repeat = value;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // wait for every answer, then let a tick in flight finish
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic tick_repeat(input logic [7:0] levels, input int n);
      for (int i = 0; i < n; i++) begin
         send_word(kdeq_pkg::CMD_TICK, levels, 3'($urandom_range(0, 7)));
      end
   endtask

   task automatic get_repeat(input int n);
      for (int i = 0; i < n; i++) begin
         send_word(kdeq_pkg::CMD_GET, 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)));
      end
   endtask

   task automatic test_reset_defaults();
      get_repeat(1);
      tick_repeat(8'h00, 1);
      get_repeat(1);
   endtask

   task automatic test_press_hold_release();
      drain_block();
      csr_write(kdeq_pkg::REG_KEYS_IN_USE, 16'd8);
      csr_write(kdeq_pkg::REG_ACTIVE_LOW, 16'h0080);
      csr_write(kdeq_pkg::REG_PRESS_FILTER, 16'd2);
      csr_write(kdeq_pkg::REG_REPEAT, 16'd2);
      tick_repeat(8'h80, 3);
      tick_repeat(8'h81, 4);
      tick_repeat(8'h80, 3);
      get_repeat(5);
   endtask

   task automatic test_priority_and_suppress();
      tick_repeat(8'h22, 2);
      get_repeat(1);
      send_word(kdeq_pkg::CMD_SUPPRESS, 8'h22, 3'd7);
      tick_repeat(8'h22, 1);
      send_word(CMD_UNKNOWN, 8'hff, 3'd7);
      tick_repeat(8'h22, 1);
      get_repeat(2);
   endtask

   task automatic test_queue_overflow();
      drain_block();
      csr_write(kdeq_pkg::REG_REPEAT, 16'd1);
      tick_repeat(8'h22, 11);
      get_repeat(9);
   endtask

   task automatic test_disabled_keys();
      tick_repeat(8'h22, 1);
      drain_block();
      csr_write(kdeq_pkg::REG_KEYS_IN_USE, 16'd0);
      get_repeat(1);
      tick_repeat(8'h22, 1);
      drain_block();
      csr_write(kdeq_pkg::REG_KEYS_IN_USE, 16'd15);
      tick_repeat(8'h22, 1);
      get_repeat(3);
   endtask

   task automatic test_random_traffic();
      logic [7:0]  held;
      logic [7:0]  lv;
      logic [3:0]  keys;
      logic [7:0]  low;
      logic [15:0] filter;
      logic [15:0] rep;
      int          roll;
      bit          noisy;
      held = 8'h00;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         keys   = 4'($urandom_range(1, 8));
         low    = 8'($urandom_range(0, 255));
         filter = 16'($urandom_range(2, 5));
         rep    = 16'($urandom_range(1, 8));
         case (p)
            2:  begin filter = 16'd0; rep = 16'd0; end
            4:  begin filter = 16'd1; rep = 16'hffff; end
            6:  keys = 4'd0;
            8:  begin keys = 4'd15; low = 8'hff; filter = 16'hffff; end
            10: begin low = 8'h00; rep = 16'd0; end
            default: begin
            end
         endcase
         drain_block();
         csr_write(kdeq_pkg::REG_KEYS_IN_USE, {12'd0, keys});
         csr_write(kdeq_pkg::REG_ACTIVE_LOW, {8'd0, low});
         csr_write(kdeq_pkg::REG_PRESS_FILTER, filter);
         csr_write(kdeq_pkg::REG_REPEAT, rep);
         calm_sender   = ($urandom_range(0, 3) == 0);
         calm_receiver = ($urandom_range(0, 3) == 0);
         noisy         = ($urandom_range(0, 4) == 0);
         // clear counters left deep by earlier settings
         for (int k = 0; k < KEY_COUNT; k++) begin
            send_word(kdeq_pkg::CMD_SUPPRESS, 8'($urandom_range(0, 255)), k[2:0]);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
               if ($urandom_range(0, 11) == 0) held[k] = ~held[k];
            end
            lv = held ^ cfg_low;
            if (noisy) begin
               lv = 8'($urandom_range(0, 255));
            end else if ($urandom_range(0, 7) == 0) begin
               lv = lv ^ 8'($urandom_range(0, 255));
            end
            roll = $urandom_range(0, 99);
            if (roll < 64) begin
               send_word(kdeq_pkg::CMD_TICK, lv, 3'($urandom_range(0, 7)));
            end else if (roll < 90) begin
               send_word(kdeq_pkg::CMD_GET, 8'($urandom_range(0, 255)),
                         3'($urandom_range(0, 7)));
            end else if (roll < 97) begin
               send_word(kdeq_pkg::CMD_SUPPRESS, lv, 3'($urandom_range(0, 7)));
            end else begin
               send_word(CMD_UNKNOWN, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
            end
         end
      end
      calm_sender   = 1'b0;
      calm_receiver = 1'b0;
   endtask

   // event answer checker
   initial begin
      int             gap;
      event_word_type want;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         gap = calm_receiver ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         if (expected_words.size() == 0) begin
            $error("unexpected word: event_valid %0d event_kind %0d event_key %0d",
                   rsp_tuser[0], rsp_tdata[1:0], rsp_tdata[4:2]);
            mismatch_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_tuser[0] !== want.valid) begin
               $error("event_valid expected %0d actual %0d", want.valid, rsp_tuser[0]);
               mismatch_count++;
            end
            if (rsp_tdata[1:0] !== want.kind) begin
               $error("event_kind expected %0d actual %0d", want.kind, rsp_tdata[1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[4:2] !== want.key) begin
               $error("event_key expected %0d actual %0d", want.key, rsp_tdata[4:2]);
               mismatch_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_press_hold_release();
      test_priority_and_suppress();
      test_queue_overflow();
      test_disabled_keys();
      test_random_traffic();
      drain_block();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/kdeq_pkg.sv
design/kdeq_key_unit.sv
design/key_debounce_event_queue.sv
bench/tb_top.sv
